FILE: src/pkra_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pkra_pkg;

  localparam int unsigned NumButtons = 16;
  localparam int unsigned KeyW       = 16;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned CntW       = 8;
  localparam int unsigned ModeW      = 2;
  localparam int unsigned TargetW    = 4;
  localparam int unsigned MapW       = NumButtons * TargetW;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 64;

  localparam logic [ByteW-1:0] PadFailStatus  = 8'hFF;
  localparam logic [ByteW-1:0] PadTypeDigital = 8'h41;

  localparam logic [CntW-1:0] ResetInitialCount = 8'd15;
  localparam logic [CntW-1:0] ResetRepeatCount  = 8'd3;

  localparam logic [CfgIdxW-1:0] RegRemapMode    = 2'd0;
  localparam logic [CfgIdxW-1:0] RegButtonMap    = 2'd1;
  localparam logic [CfgIdxW-1:0] RegInitialCount = 2'd2;
  localparam logic [CfgIdxW-1:0] RegRepeatCount  = 2'd3;

  typedef struct packed {
    logic [ByteW-1:0] pad1_status;
    logic [ByteW-1:0] pad1_type;
    logic [KeyW-1:0]  pad1_raw_keys;
    logic [ByteW-1:0] pad2_status;
    logic [ByteW-1:0] pad2_type;
    logic [KeyW-1:0]  pad2_raw_keys;
    logic             override_active;
    logic [KeyW-1:0]  override_keys;
  } in_item_t;

  typedef struct packed {
    logic [KeyW-1:0] pad1_held;
    logic [KeyW-1:0] pad1_pressed;
    logic [KeyW-1:0] pad1_repeat;
    logic [KeyW-1:0] pad2_held;
    logic [KeyW-1:0] pad2_pressed;
    logic [KeyW-1:0] pad2_repeat;
  } out_item_t;

  typedef struct packed {
    logic step;
    logic changed;
  } tm_ctrl_t;

  typedef struct packed {
    logic [CntW-1:0] initial_count;
    logic [CntW-1:0] repeat_count;
  } tm_cfg_t;

endpackage

`default_nettype wire

FILE: src/pkra_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pkra_in_if;
  logic               valid;
  logic               ready;
  pkra_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pkra_out_if;
  logic                valid;
  logic                ready;
  pkra_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: src/pkra_typematic.sv
`timescale 1ns / 1ps
`default_nettype none

module pkra_typematic (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire pkra_pkg::tm_ctrl_t ctrl_i,
  input  wire pkra_pkg::tm_cfg_t  cfg_i,
  output logic                    fire_o
);

  logic [pkra_pkg::CntW-1:0] cnt_q, cnt_d;
  logic                      rep_q, rep_d;

  always_comb begin
    cnt_d  = cnt_q;
    rep_d  = rep_q;
    fire_o = 1'b0;
    if (ctrl_i.step) begin
      if (ctrl_i.changed) begin
        cnt_d = '0;
        rep_d = 1'b0;
      end else if (rep_q) begin
        if (cnt_q == cfg_i.repeat_count) begin
          cnt_d  = '0;
          fire_o = 1'b1;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end else if (cnt_q == cfg_i.initial_count) begin
        cnt_d = '0;
        rep_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rep_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      rep_q <= rep_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/pad_key_remap_autorepeat_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Each beat passes from the input register to the result register; a stalled result holds it back.
// Throughput: one beat per cycle while results are taken; input register, typematic logic, result register.
// The input side keeps accepting while a result waits, until both stages are full.
// Reset clears the pipeline, the per-pad key history, counters and the pad 2 repeat
// word, and returns the registers to remap off, empty map, counts of 15 and 3.

module pad_key_remap_autorepeat_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  pkra_in_if.sink                              in_i,
  pkra_out_if.source                           out_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [pkra_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [pkra_pkg::CfgDataW-1:0]   cfg_data_i
);

  localparam int unsigned KeyW = pkra_pkg::KeyW;

  function automatic logic [KeyW-1:0] decode_pad(logic [pkra_pkg::ByteW-1:0] status,
                                                 logic [pkra_pkg::ByteW-1:0] ptype,
                                                 logic [KeyW-1:0] raw);
    logic [KeyW-1:0] keys;
    keys = ~raw;
    if (status == pkra_pkg::PadFailStatus || ptype != pkra_pkg::PadTypeDigital) begin
      keys = '0;
    end
    return keys;
  endfunction

  function automatic logic [KeyW-1:0] remap_keys(logic [KeyW-1:0] keys,
                                                 logic [pkra_pkg::MapW-1:0] map);
    logic [KeyW-1:0] res;
    res = '0;
    for (int i = 0; i < pkra_pkg::NumButtons; i++) begin
      if (keys[i]) begin
        res[map[i*pkra_pkg::TargetW +: pkra_pkg::TargetW]] = 1'b1;
      end
    end
    return res;
  endfunction

  logic [pkra_pkg::ModeW-1:0] remap_mode_q;
  logic [pkra_pkg::MapW-1:0]  button_map_q;
  pkra_pkg::tm_cfg_t          tm_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remap_mode_q           <= '0;
      button_map_q           <= '0;
      tm_cfg_q.initial_count <= pkra_pkg::ResetInitialCount;
      tm_cfg_q.repeat_count  <= pkra_pkg::ResetRepeatCount;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pkra_pkg::RegRemapMode: begin
          remap_mode_q <= cfg_data_i[pkra_pkg::ModeW-1:0];
        end
        pkra_pkg::RegButtonMap: begin
          button_map_q <= cfg_data_i[pkra_pkg::MapW-1:0];
        end
        pkra_pkg::RegInitialCount: begin
          tm_cfg_q.initial_count <= cfg_data_i[pkra_pkg::CntW-1:0];
        end
        pkra_pkg::RegRepeatCount: begin
          tm_cfg_q.repeat_count <= cfg_data_i[pkra_pkg::CntW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  logic                in_v_q;
  pkra_pkg::in_item_t  in_q;
  logic                out_v_q;
  pkra_pkg::out_item_t out_q, out_d;
  logic                out_free;
  logic                adv;

  assign out_free   = !out_v_q || out_o.ready;
  assign adv        = in_v_q && out_free;
  assign in_i.ready = !in_v_q || adv;

  logic [KeyW-1:0] last1_q, last2_q, rep2_q, rep2_d;
  logic [KeyW-1:0] k1_raw, k1, k2, p1, p2;
  logic            ch1, ch2, fire1, fire2;
  pkra_pkg::tm_ctrl_t tm1_ctrl, tm2_ctrl;

  always_comb begin
    if (in_q.override_active) begin
      k1_raw = in_q.override_keys;
    end else begin
      k1_raw = decode_pad(in_q.pad1_status, in_q.pad1_type, in_q.pad1_raw_keys);
    end
    if (remap_mode_q != '0 && !in_q.override_active) begin
      k1 = remap_keys(k1_raw, button_map_q);
    end else begin
      k1 = k1_raw;
    end
    k2  = decode_pad(in_q.pad2_status, in_q.pad2_type, in_q.pad2_raw_keys);
    p1  = k1 & ~last1_q;
    p2  = k2 & ~last2_q;
    ch1 = k1 != last1_q;
    ch2 = k2 != last2_q;
  end

  assign tm1_ctrl = '{step: adv, changed: ch1};
  assign tm2_ctrl = '{step: adv, changed: ch2};

  pkra_typematic u_tm1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (tm1_ctrl),
    .cfg_i  (tm_cfg_q),
    .fire_o (fire1)
  );

  pkra_typematic u_tm2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (tm2_ctrl),
    .cfg_i  (tm_cfg_q),
    .fire_o (fire2)
  );

  // Pad 2 keeps its previous repeat word, plus new presses, on a frame where its keys change.
  always_comb begin
    if (ch2) begin
      rep2_d = rep2_q | p2;
    end else begin
      rep2_d = (fire2 ? k2 : '0) | p2;
    end
    out_d.pad1_held    = k1;
    out_d.pad1_pressed = p1;
    out_d.pad1_repeat  = (fire1 ? k1 : '0) | p1;
    out_d.pad2_held    = k2;
    out_d.pad2_pressed = p2;
    out_d.pad2_repeat  = rep2_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      last1_q <= '0;
      last2_q <= '0;
      rep2_q  <= '0;
    end else begin
      if (in_i.ready) begin
        in_v_q <= in_i.valid;
      end
      if (out_free) begin
        out_v_q <= adv;
      end
      if (adv) begin
        last1_q <= k1;
        last2_q <= k2;
        rep2_q  <= rep2_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q <= in_i.data;
    end
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = out_v_q;
  assign out_o.data  = out_q;

endmodule

`default_nettype wire

FILE: src/pkra_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module pkra_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_i,
  input wire logic                out_valid_i,
  input wire logic                out_ready_i,
  input wire pkra_pkg::out_item_t out_data_i
);

  // A stalled result beat keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result beat changed while stalled");

  // With no result pending the input side is never blocked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output");

  // New presses are always among the held keys.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((out_data_i.pad1_pressed & ~out_data_i.pad1_held) == '0) &&
                    ((out_data_i.pad2_pressed & ~out_data_i.pad2_held) == '0))
    else $error("pressed key not held");

  // New presses always appear in the repeat word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((out_data_i.pad1_pressed & ~out_data_i.pad1_repeat) == '0) &&
                    ((out_data_i.pad2_pressed & ~out_data_i.pad2_repeat) == '0))
    else $error("pressed key missing from repeat word");

endmodule

bind pad_key_remap_autorepeat_core pkra_checker u_pkra_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import pkra_pkg::*;

  localparam int unsigned CycleLimit = 200000;

  typedef enum logic {RowBeat, RowWrite} row_kind_e;

  typedef struct {
    row_kind_e            kind;
    logic [CfgIdxW-1:0]   idx;
    logic [CfgDataW-1:0]  value;
    in_item_t             beat;
    logic                 fixed;
    out_item_t            want;
  } row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  pkra_in_if  pad_in ();
  pkra_out_if pad_out ();

  pad_key_remap_autorepeat_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (pad_in),
    .out_o      (pad_out),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Register copies and per-pad history used for prediction.
  logic [ModeW-1:0] sh_remap = '0;
  logic [MapW-1:0]  sh_map   = '0;
  logic [CntW-1:0]  sh_init  = ResetInitialCount;
  logic [CntW-1:0]  sh_rep   = ResetRepeatCount;

  logic [KeyW-1:0] p1_prev = '0;
  logic [KeyW-1:0] p2_prev = '0;
  logic [CntW-1:0] p1_tick = '0;
  logic [CntW-1:0] p2_tick = '0;
  logic            p1_rpt  = 1'b0;
  logic            p2_rpt  = 1'b0;
  logic [KeyW-1:0] p2_word = '0;

  out_item_t frames_due[$];
  out_item_t want_now;
  row_t      script[$];

  int   mismatches   = 0;
  int   results_seen = 0;
  int   cycles_run   = 0;
  logic calm         = 1'b0;
  logic stall_done   = 1'b0;

  logic [KeyW-1:0] keys1_now    = '0;
  logic [KeyW-1:0] keys2_now    = '0;
  logic            override_now = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [KeyW-1:0] decode_reply(logic [ByteW-1:0] st, logic [ByteW-1:0] ty,
                                                   logic [KeyW-1:0] raw);
    if (st == PadFailStatus || ty != PadTypeDigital) return '0;
    return ~raw;
  endfunction

  function automatic logic [KeyW-1:0] remap_pad1(logic [KeyW-1:0] keys);
    logic [KeyW-1:0] res;
    res = '0;
    for (int i = 0; i < NumButtons; i++) begin
      if (keys[i]) res[sh_map[TargetW*i +: TargetW]] = 1'b1;
    end
    return res;
  endfunction

  function automatic logic tick_counter(input logic changed, inout logic [CntW-1:0] cnt,
                                        inout logic rpt);
    logic fire;
    fire = 1'b0;
    if (changed) begin
      cnt = '0;
      rpt = 1'b0;
    end else if (rpt) begin
      if (cnt == sh_rep) begin
        cnt  = '0;
        fire = 1'b1;
      end else begin
        cnt = cnt + 1'b1;
      end
    end else if (cnt == sh_init) begin
      rpt = 1'b1;
      cnt = '0;
    end else begin
      cnt = cnt + 1'b1;
    end
    return fire;
  endfunction

  function automatic out_item_t predict_frame(in_item_t b);
    out_item_t       r;
    logic [KeyW-1:0] k1;
    logic [KeyW-1:0] k2;
    logic            f1;
    logic            f2;
    logic            c2;
    if (b.override_active) k1 = b.override_keys;
    else k1 = decode_reply(b.pad1_status, b.pad1_type, b.pad1_raw_keys);
    k2 = decode_reply(b.pad2_status, b.pad2_type, b.pad2_raw_keys);
    if (sh_remap != '0 && !b.override_active) k1 = remap_pad1(k1);

    r.pad1_held    = k1;
    r.pad1_pressed = k1 & ~p1_prev;
    f1 = tick_counter(k1 != p1_prev, p1_tick, p1_rpt);
    r.pad1_repeat  = (f1 ? k1 : '0) | r.pad1_pressed;

    // Pad 2 keeps its previous repeat word, plus new presses, on a frame where its keys change.
    r.pad2_held    = k2;
    r.pad2_pressed = k2 & ~p2_prev;
    c2 = k2 != p2_prev;
    f2 = tick_counter(c2, p2_tick, p2_rpt);
    if (!c2) p2_word = f2 ? k2 : '0;
    p2_word        = p2_word | r.pad2_pressed;
    r.pad2_repeat  = p2_word;

    p1_prev = k1;
    p2_prev = k2;
    return r;
  endfunction

  function automatic in_item_t reply(logic [ByteW-1:0] s1, logic [ByteW-1:0] t1,
                                     logic [KeyW-1:0] r1, logic [ByteW-1:0] s2,
                                     logic [ByteW-1:0] t2, logic [KeyW-1:0] r2,
                                     logic ovr, logic [KeyW-1:0] ovr_keys);
    return in_item_t'{s1, t1, r1, s2, t2, r2, ovr, ovr_keys};
  endfunction

  function automatic void add_beat(in_item_t b);
    script.push_back('{RowBeat, '0, '0, b, 1'b0, '0});
  endfunction

  function automatic void add_fixed(in_item_t b, out_item_t w);
    script.push_back('{RowBeat, '0, '0, b, 1'b1, w});
  endfunction

  function automatic void add_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    script.push_back('{RowWrite, idx, value, '0, 1'b0, '0});
  endfunction

  function automatic logic [KeyW-1:0] pick_keys();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return 16'h0001 << $urandom_range(15);
      default: return KeyW'($urandom);
    endcase
  endfunction

  function automatic void encode_reply(input logic [KeyW-1:0] keys, input int noise_pct,
                                       output logic [ByteW-1:0] st,
                                       output logic [ByteW-1:0] ty,
                                       output logic [KeyW-1:0] raw);
    if ($urandom_range(99) < noise_pct) begin
      raw = KeyW'($urandom);
      ty  = ByteW'($urandom);
      if ($urandom_range(1)) begin
        st = PadFailStatus;
      end else begin
        st = ByteW'($urandom_range(0, 254));
        if (ty == PadTypeDigital) ty = ~ty;
      end
    end else begin
      st  = ByteW'($urandom_range(0, 254));
      ty  = PadTypeDigital;
      raw = ~keys;
    end
  endfunction

  function automatic in_item_t next_frame(int change_pct, int noise_pct);
    in_item_t b;
    if ($urandom_range(99) < change_pct) keys1_now = pick_keys();
    if ($urandom_range(99) < change_pct) keys2_now = pick_keys();
    if ($urandom_range(99) < change_pct / 4) override_now = ~override_now;
    b.override_active = override_now;
    b.override_keys   = override_now ? keys1_now : KeyW'($urandom);
    if (override_now) begin
      b.pad1_status   = ByteW'($urandom);
      b.pad1_type     = ByteW'($urandom);
      b.pad1_raw_keys = KeyW'($urandom);
    end else begin
      encode_reply(keys1_now, noise_pct, b.pad1_status, b.pad1_type, b.pad1_raw_keys);
    end
    encode_reply(keys2_now, noise_pct, b.pad2_status, b.pad2_type, b.pad2_raw_keys);
    return b;
  endfunction

  task automatic report(string msg);
    mismatches++;
    if (mismatches <= 40) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [KeyW-1:0] got, logic [KeyW-1:0] want);
    if (got !== want) report($sformatf("result %0d %s: got %h, expected %h",
                                       results_seen, name, got, want));
  endtask

  task automatic wait_drained();
    pad_in.valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    wait_drained();
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    case (idx)
      RegRemapMode:    sh_remap = value[ModeW-1:0];
      RegButtonMap:    sh_map   = value[MapW-1:0];
      RegInitialCount: sh_init  = value[CntW-1:0];
      RegRepeatCount:  sh_rep   = value[CntW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic send_beat(in_item_t b, logic fixed, out_item_t fixed_want);
    out_item_t predicted;
    cfg_we <= 1'b0;
    if (!calm && $urandom_range(5) == 0) begin
      pad_in.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    pad_in.valid <= 1'b1;
    pad_in.data  <= b;
    do @(posedge clk_i); while (!pad_in.ready);
    predicted = predict_frame(b);
    frames_due.push_back(fixed ? fixed_want : predicted);
  endtask

  task automatic run_stream(int count, int change_pct, int noise_pct);
    repeat (count) send_beat(next_frame(change_pct, noise_pct), 1'b0, '0);
  endtask

  task automatic shuffle_regs();
    write_reg(RegRemapMode, CfgDataW'($urandom_range(0, 3)));
    write_reg(RegButtonMap, {$urandom, $urandom});
    write_reg(RegInitialCount, CfgDataW'($urandom_range(0, 6)));
    write_reg(RegRepeatCount, CfgDataW'($urandom_range(0, 4)));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && pad_out.valid && pad_out.ready) begin
      results_seen++;
      if (frames_due.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want_now = frames_due.pop_front();
        check_field("pad1_held", pad_out.data.pad1_held, want_now.pad1_held);
        check_field("pad1_pressed", pad_out.data.pad1_pressed, want_now.pad1_pressed);
        check_field("pad1_repeat", pad_out.data.pad1_repeat, want_now.pad1_repeat);
        check_field("pad2_held", pad_out.data.pad2_held, want_now.pad2_held);
        check_field("pad2_pressed", pad_out.data.pad2_pressed, want_now.pad2_pressed);
        check_field("pad2_repeat", pad_out.data.pad2_repeat, want_now.pad2_repeat);
      end
    end
  end

  // The receiver stalls once for a long stretch so that both pipeline stages fill up.
  initial begin
    pad_out.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (!stall_done && results_seen >= 80) begin
        stall_done = 1'b1;
        pad_out.ready <= 1'b0;
        repeat (48) @(posedge clk_i);
      end else if (!calm && $urandom_range(7) == 0) begin
        pad_out.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end
      pad_out.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  initial begin
    while (cycles_run < CycleLimit) begin
      @(posedge clk_i);
      cycles_run++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst_ni       = 1'b0;
    pad_in.valid = 1'b0;
    pad_in.data  = '0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_data     = '0;

    add_fixed(reply(8'hFF, PadTypeDigital, 16'h0000, 8'h00, PadTypeDigital, 16'hFFFF,
                    1'b0, 16'h0000),
              out_item_t'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000});
    add_fixed(reply(8'h00, PadTypeDigital, 16'h0000, 8'hFE, PadTypeDigital, 16'h0000,
                    1'b0, 16'hFFFF),
              out_item_t'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    add_fixed(reply(8'h00, 8'h00, 16'h0000, 8'h00, 8'hFF, 16'h0000, 1'b0, 16'h0000),
              out_item_t'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF});
    add_fixed(reply(8'hFF, 8'hFF, 16'hFFFF, 8'h7F, PadTypeDigital, 16'h5A5A, 1'b1, 16'hA5A5),
              out_item_t'{16'hA5A5, 16'hA5A5, 16'hA5A5, 16'hA5A5, 16'hA5A5, 16'hFFFF});
    add_write(RegInitialCount, 64'd0);
    add_write(RegRepeatCount, 64'd0);
    repeat (3) add_beat(reply(8'hFF, 8'hFF, 16'hFFFF, 8'h7F, PadTypeDigital, 16'h5A5A,
                              1'b1, 16'hA5A5));
    add_write(RegInitialCount, 64'd255);
    add_write(RegRepeatCount, 64'd255);
    repeat (2) add_beat(reply(8'h01, PadTypeDigital, 16'h7FFF, 8'h80, PadTypeDigital,
                              16'hFFFE, 1'b0, 16'h0000));
    add_write(RegRemapMode, 64'd1);
    add_write(RegButtonMap, 64'h0123_4567_89AB_CDEF);
    add_beat(reply(8'h01, PadTypeDigital, 16'h7FFF, 8'h80, PadTypeDigital, 16'hFFFE,
                   1'b0, 16'h0000));
    add_beat(reply(8'hFF, 8'hFF, 16'hFFFF, 8'h7F, PadTypeDigital, 16'h5A5A, 1'b1, 16'hA5A5));
    add_beat(reply(8'hFF, PadTypeDigital, 16'h0000, 8'h00, PadTypeDigital, 16'hFFFF,
                   1'b0, 16'h0000));
    add_beat(reply(8'h00, PadTypeDigital, 16'h0000, 8'h00, PadTypeDigital, 16'hFFFF,
                   1'b0, 16'h0000));
    add_write(RegButtonMap, 64'd0);
    add_beat(reply(8'h00, PadTypeDigital, 16'hFF00, 8'h00, PadTypeDigital, 16'hFFFF,
                   1'b0, 16'h0000));
    add_write(RegButtonMap, '1);
    add_beat(reply(8'h00, PadTypeDigital, 16'hFF00, 8'h00, PadTypeDigital, 16'hFFFF,
                   1'b0, 16'h0000));
    add_beat(reply(8'h00, PadTypeDigital, 16'hFFFF, 8'h00, PadTypeDigital, 16'h0000,
                   1'b1, 16'hFFFF));
    add_beat(reply(8'h00, PadTypeDigital, 16'h0000, 8'h00, PadTypeDigital, 16'h0000,
                   1'b1, 16'h0000));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[i]) begin
      if (script[i].kind == RowWrite) write_reg(script[i].idx, script[i].value);
      else send_beat(script[i].beat, script[i].fixed, script[i].want);
    end

    write_reg(RegRemapMode, 64'd2);
    write_reg(RegButtonMap, {$urandom, $urandom});
    write_reg(RegInitialCount, CfgDataW'($urandom_range(0, 6)));
    write_reg(RegRepeatCount, CfgDataW'($urandom_range(0, 4)));
    run_stream(120, 12, 8);

    // Every pad 1 button lands on bit 0, then on bit 15, except on override frames.
    write_reg(RegRemapMode, 64'd3);
    write_reg(RegButtonMap, 64'd0);
    write_reg(RegInitialCount, 64'd2);
    write_reg(RegRepeatCount, 64'd1);
    run_stream(60, 12, 8);
    write_reg(RegRemapMode, 64'd1);
    write_reg(RegButtonMap, '1);
    run_stream(60, 12, 8);

    // Lowering a target under a running counter makes it wrap through 255.
    write_reg(RegRemapMode, 64'd0);
    write_reg(RegInitialCount, 64'd0);
    write_reg(RegRepeatCount, 64'd250);
    run_stream(1, 100, 0);
    run_stream(30, 0, 0);
    write_reg(RegRepeatCount, 64'd3);
    run_stream(260, 0, 0);
    write_reg(RegInitialCount, 64'd250);
    write_reg(RegRepeatCount, CfgDataW'($urandom_range(0, 4)));
    run_stream(1, 100, 0);
    run_stream(20, 0, 0);
    write_reg(RegInitialCount, 64'd4);
    run_stream(250, 0, 0);

    shuffle_regs();
    run_stream(100, 15, 10);

    shuffle_regs();
    wait_drained();
    calm = 1'b1;
    run_stream(80, 12, 8);

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
